@@ src/fimc_pkg.sv @@
// ----------------------------------------------------------------------------
// fimc_pkg
// constants, control word types and the microcode table of the matrix cell
// ----------------------------------------------------------------------------
package fimc_pkg;

    localparam int FRAC_BITS = 15;
    localparam int Q_ONE     = 1 << FRAC_BITS;

    localparam int IN_W   = 16;
    localparam int V_W    = 17;
    localparam int A_W    = 40;
    localparam int B_W    = 18;
    localparam int PR_W   = A_W + B_W;
    localparam int RM_W   = PR_W - FRAC_BITS;
    localparam int RV_W   = RM_W + 1;
    localparam int F_W    = 32;
    localparam int K_W    = 36;
    localparam int X_W    = 35;
    localparam int C_W    = 21;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 24;

    localparam longint F_MAX = 64'sd2147483647;
    localparam longint F_MIN = -64'sd2147483648;
    localparam longint C_MAX = 64'sd1048575;
    localparam longint C_MIN = -64'sd1048576;

    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 20;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_IMP1_E2,
        MUL_IMP1X4_E,
        MUL_P_NOTD,
        MUL_U_IMP2,
        MUL_W_NOTE,
        MUL_F_FV,
        MUL_F_G3,
        MUL_K_G,
        MUL_X1_G,
        MUL_Y_NOTG
    } mul_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_T1,
        WB_U,
        WB_P,
        WB_W,
        WB_FV,
        WB_F,
        WB_K,
        WB_X1,
        WB_Y,
        WB_X,
        WB_C
    } wb_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_EXIT_NOT_LAST,
        SEQ_EMIT
    } seq_op_t;

    typedef struct packed {
        mul_op_t mul_op;
        wb_op_t  wb_op;
        seq_op_t seq_op;
    } ctrl_t;

    // a product is written back once it has passed the product and rounding registers
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            w = '{mul_op: MUL_NONE, wb_op: WB_NONE, seq_op: SEQ_NEXT};
            unique case (step)
                5'd0:  w.mul_op = MUL_IMP1_E2;
                5'd1:  w.mul_op = MUL_IMP1X4_E;
                5'd2:
                begin
                    w.mul_op = MUL_P_NOTD;
                    w.wb_op  = WB_T1;
                end
                5'd3:  w.wb_op = WB_U;
                5'd4:
                begin
                    w.mul_op = MUL_U_IMP2;
                    w.wb_op  = WB_P;
                end
                5'd6:  w.wb_op = WB_W;
                5'd7:  w.mul_op = MUL_W_NOTE;
                5'd9:  w.wb_op = WB_FV;
                5'd10: w.mul_op = MUL_F_FV;
                5'd12:
                begin
                    w.wb_op  = WB_F;
                    w.seq_op = SEQ_EXIT_NOT_LAST;
                end
                5'd13:
                begin
                    w.mul_op = MUL_F_G3;
                    w.wb_op  = WB_K;
                end
                5'd14: w.mul_op = MUL_K_G;
                5'd15: w.wb_op = WB_X1;
                5'd16:
                begin
                    w.mul_op = MUL_X1_G;
                    w.wb_op  = WB_Y;
                end
                5'd17: w.mul_op = MUL_Y_NOTG;
                5'd18: w.wb_op = WB_X;
                5'd19: w.wb_op = WB_C;
                5'd20: w.seq_op = SEQ_EMIT;
                default: w = '{mul_op: MUL_NONE, wb_op: WB_NONE, seq_op: SEQ_NEXT};
            endcase
            return w;
        end
    endfunction

endpackage

@@ src/fuzzy_implication_matrix_cell.sv @@
// ----------------------------------------------------------------------------
// fuzzy_implication_matrix_cell
// one cell of a fuzzy implication matrix composition, one element per request
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one element request: a, b, e and g in s_tdata, s_tlast marks
//   the final element of the cell's vector. m_* carries the cell result c,
//   sent once per vector, on the request marked last.
//   a request is taken when s_tvalid and s_tready are high; s_tready is high
//   whenever the sequencer is idle.
//   a microcode table of 21 steps drives one 40x18 multiplier, a rounding
//   stage and a small writeback unit; a product is written back once it has
//   passed the product and rounding registers. s_tready stays low until an
//   element's steps are done, and for a last element also until the output
//   register is free, so a new request waits for the one before it.
//   c appears in the output register in the cycle after the last step and stays
//   there until taken; a new request is accepted while it waits.
//   if the receiver stalls, the next last element holds at its final step
//   until the output register is free.
//   reset clears the sequencer and the output valid flag and sets both running
//   products to 1.0.
// ----------------------------------------------------------------------------
module fuzzy_implication_matrix_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_value[15:0], b_value[31:16], e_value[47:32], g_value[63:48]
    input  logic [fimc_pkg::TDATA_IN_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // c_value[20:0], zeros above
    output logic [fimc_pkg::TDATA_OUT_W-1:0] m_tdata
);

    localparam int A_W  = fimc_pkg::A_W;
    localparam int B_W  = fimc_pkg::B_W;
    localparam int PR_W = fimc_pkg::PR_W;
    localparam int RM_W = fimc_pkg::RM_W;
    localparam int RV_W = fimc_pkg::RV_W;
    localparam int V_W  = fimc_pkg::V_W;
    localparam int IN_W = fimc_pkg::IN_W;
    localparam int F_W  = fimc_pkg::F_W;
    localparam int K_W  = fimc_pkg::K_W;
    localparam int X_W  = fimc_pkg::X_W;
    localparam int C_W  = fimc_pkg::C_W;
    localparam int FB   = fimc_pkg::FRAC_BITS;
    localparam int SW   = fimc_pkg::STEP_W;

    localparam logic [V_W-1:0]         ONE_V    = V_W'(fimc_pkg::Q_ONE);
    localparam logic [IN_W-1:0]        ONE_IN   = IN_W'(fimc_pkg::Q_ONE);
    localparam logic signed [A_W-1:0]  ONE_A    = A_W'(fimc_pkg::Q_ONE);
    localparam logic signed [B_W-1:0]  ONE_B    = B_W'(fimc_pkg::Q_ONE);
    localparam logic signed [RV_W-1:0] ONE_RV   = RV_W'(fimc_pkg::Q_ONE);
    localparam logic signed [K_W-1:0]  ONE_K    = K_W'(fimc_pkg::Q_ONE);
    localparam logic signed [F_W-1:0]  ONE_F    = F_W'(fimc_pkg::Q_ONE);
    localparam logic [PR_W-1:0]        RND_HALF = PR_W'(1) << (FB - 1);

    function automatic logic [IN_W-1:0] clamp_in(input logic [IN_W-1:0] x);
        begin
            return (x > ONE_IN) ? ONE_IN : x;
        end
    endfunction

    // sequencer
    logic                  busy_reg;
    logic                  busy_next;
    logic [SW-1:0]         step_reg;
    logic [SW-1:0]         step_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [C_W-1:0]        out_data_reg;
    fimc_pkg::ctrl_t       ctrl;
    logic                  in_fire;
    logic                  emit_fire;

    // element operands
    logic [IN_W-1:0]       a_reg;
    logic [IN_W-1:0]       b_reg;
    logic [IN_W-1:0]       e_reg;
    logic [IN_W-1:0]       g_reg;
    logic                  last_reg;

    // datapath registers
    logic signed [PR_W-1:0] prod_reg;
    logic [RM_W-1:0]        rmag_reg;
    logic                   rneg_reg;
    logic signed [V_W-1:0]  t1_reg;
    logic signed [B_W-1:0]  u_reg;
    logic signed [B_W-1:0]  w_reg;
    logic signed [B_W-1:0]  fv_reg;
    logic signed [F_W-1:0]  f_reg;
    logic [V_W-1:0]         p_reg;
    logic signed [K_W-1:0]  k_reg;
    logic signed [X_W-1:0]  x1_reg;
    logic signed [K_W-1:0]  y_reg;
    logic signed [X_W-1:0]  x_reg;
    logic signed [C_W-1:0]  c_reg;

    // combinational datapath
    logic [V_W-1:0]         imp1;
    logic [V_W-1:0]         imp2;
    logic [V_W-1:0]         dmin;
    logic signed [A_W-1:0]  imp1_a;
    logic signed [B_W-1:0]  e_b;
    logic signed [B_W-1:0]  g_b;
    logic signed [B_W-1:0]  imp2_b;
    logic signed [B_W-1:0]  d_b;
    logic signed [A_W-1:0]  op_a;
    logic signed [B_W-1:0]  op_b;
    logic [PR_W-1:0]        prod_mag;
    logic [PR_W-1:0]        prod_rnd;
    logic signed [RV_W-1:0] rval;
    logic signed [RV_W-1:0] fv_sum;
    logic signed [RV_W-1:0] y_sum;
    logic signed [RV_W-1:0] c_sum;
    logic signed [F_W-1:0]  f_sat;
    logic signed [C_W-1:0]  c_sat;
    logic signed [K_W-1:0]  f_k;
    logic signed [K_W-1:0]  p_k;
    logic signed [K_W-1:0]  h_k;
    logic signed [K_W-1:0]  d_k;
    logic signed [K_W-1:0]  k_val;

    assign ctrl      = fimc_pkg::ucode(step_reg);
    assign s_tready  = !busy_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign emit_fire = busy_reg && (ctrl.seq_op == fimc_pkg::SEQ_EMIT)
                       && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(fimc_pkg::TDATA_OUT_W - C_W){1'b0}}, out_data_reg};

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        if (in_fire)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            unique case (ctrl.seq_op)
                fimc_pkg::SEQ_NEXT:
                begin
                    step_next = step_reg + SW'(1);
                end
                fimc_pkg::SEQ_EXIT_NOT_LAST:
                begin
                    if (!last_reg)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        step_next = step_reg + SW'(1);
                    end
                end
                fimc_pkg::SEQ_EMIT:
                begin
                    if (emit_fire)
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // element terms
    always_comb
    begin
        imp1   = ((ONE_V - V_W'(a_reg)) > V_W'(b_reg)) ? (ONE_V - V_W'(a_reg)) : V_W'(b_reg);
        imp2   = ((ONE_V - V_W'(b_reg)) > V_W'(a_reg)) ? (ONE_V - V_W'(b_reg)) : V_W'(a_reg);
        dmin   = (a_reg < b_reg) ? V_W'(a_reg) : V_W'(b_reg);
        imp1_a = A_W'(imp1);
        e_b    = B_W'(e_reg);
        g_b    = B_W'(g_reg);
        imp2_b = B_W'(imp2);
        d_b    = B_W'(dmin);
    end

    // multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (ctrl.mul_op)
            fimc_pkg::MUL_NONE:
            begin
                op_a = '0;
                op_b = '0;
            end
            fimc_pkg::MUL_IMP1_E2:
            begin
                op_a = imp1_a;
                op_b = e_b + e_b - ONE_B;
            end
            fimc_pkg::MUL_IMP1X4_E:
            begin
                op_a = (imp1_a <<< 2) - ONE_A - ONE_A;
                op_b = e_b;
            end
            fimc_pkg::MUL_P_NOTD:
            begin
                op_a = A_W'(p_reg);
                op_b = ONE_B - d_b;
            end
            fimc_pkg::MUL_U_IMP2:
            begin
                op_a = A_W'(u_reg);
                op_b = imp2_b;
            end
            fimc_pkg::MUL_W_NOTE:
            begin
                op_a = A_W'(w_reg);
                op_b = ONE_B - e_b;
            end
            fimc_pkg::MUL_F_FV:
            begin
                op_a = A_W'(f_reg);
                op_b = fv_reg;
            end
            fimc_pkg::MUL_F_G3:
            begin
                op_a = A_W'(f_reg);
                op_b = g_b + g_b + g_b - ONE_B - ONE_B;
            end
            fimc_pkg::MUL_K_G:
            begin
                op_a = A_W'(k_reg);
                op_b = g_b;
            end
            fimc_pkg::MUL_X1_G:
            begin
                op_a = A_W'(x1_reg);
                op_b = g_b;
            end
            fimc_pkg::MUL_Y_NOTG:
            begin
                op_a = A_W'(y_reg);
                op_b = ONE_B - g_b;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // rounding to nearest, ties away from zero
    always_comb
    begin
        prod_mag = prod_reg[PR_W-1] ? PR_W'(-prod_reg) : PR_W'(prod_reg);
        prod_rnd = prod_mag + RND_HALF;
        rval     = rneg_reg ? -RV_W'({1'b0, rmag_reg}) : RV_W'({1'b0, rmag_reg});
    end

    // writeback arithmetic
    always_comb
    begin
        fv_sum = rval + RV_W'(t1_reg);
        y_sum  = rval + RV_W'(ONE_V - p_reg);
        c_sum  = rval + RV_W'(x_reg);
        if (rval > RV_W'(fimc_pkg::F_MAX))
        begin
            f_sat = F_W'(fimc_pkg::F_MAX);
        end
        else if (rval < RV_W'(fimc_pkg::F_MIN))
        begin
            f_sat = F_W'(fimc_pkg::F_MIN);
        end
        else
        begin
            f_sat = F_W'(rval);
        end
        if (c_sum > RV_W'(fimc_pkg::C_MAX))
        begin
            c_sat = C_W'(fimc_pkg::C_MAX);
        end
        else if (c_sum < RV_W'(fimc_pkg::C_MIN))
        begin
            c_sat = C_W'(fimc_pkg::C_MIN);
        end
        else
        begin
            c_sat = C_W'(c_sum);
        end
        // 4*max(F - P, 0) - 3*(1 - P)
        f_k   = K_W'(f_reg);
        p_k   = K_W'(p_reg);
        h_k   = (f_k > p_k) ? (f_k - p_k) : '0;
        d_k   = ONE_K - p_k;
        k_val = (h_k <<< 2) - d_k - d_k - d_k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            f_reg         <= ONE_F;
            p_reg         <= ONE_V;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (emit_fire)
            begin
                f_reg <= ONE_F;
                p_reg <= ONE_V;
            end
            else if (busy_reg && (ctrl.wb_op == fimc_pkg::WB_F))
            begin
                f_reg <= f_sat;
            end
            else if (busy_reg && (ctrl.wb_op == fimc_pkg::WB_P))
            begin
                p_reg <= V_W'(rval);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        rmag_reg <= prod_rnd[PR_W-1:FB];
        rneg_reg <= prod_reg[PR_W-1];
        if (in_fire)
        begin
            a_reg    <= clamp_in(s_tdata[15:0]);
            b_reg    <= clamp_in(s_tdata[31:16]);
            e_reg    <= clamp_in(s_tdata[47:32]);
            g_reg    <= clamp_in(s_tdata[63:48]);
            last_reg <= s_tlast;
        end
        if (emit_fire)
        begin
            out_data_reg <= c_reg;
        end
        if (busy_reg)
        begin
            case (ctrl.wb_op)
                fimc_pkg::WB_T1: t1_reg <= V_W'(rval);
                fimc_pkg::WB_U:  u_reg  <= B_W'(rval + ONE_RV);
                fimc_pkg::WB_W:  w_reg  <= B_W'(rval);
                fimc_pkg::WB_FV: fv_reg <= B_W'(fv_sum);
                fimc_pkg::WB_K:  k_reg  <= k_val;
                fimc_pkg::WB_X1: x1_reg <= X_W'(rval);
                fimc_pkg::WB_Y:  y_reg  <= K_W'(y_sum);
                fimc_pkg::WB_X:  x_reg  <= X_W'(rval);
                fimc_pkg::WB_C:  c_reg  <= c_sat;
                default:
                begin
                end
            endcase
        end
    end

    // checks
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= SW'(fimc_pkg::LAST_STEP)))
        else $error("step counter past end of program");

    a_prod_reset: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (f_reg == ONE_F) && (p_reg == ONE_V))
        else $error("running products not returned to one after result");

    a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= ONE_V)
        else $error("product of complements above one");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg) && $past(last_reg))
        else $error("result raised without a last element");

endmodule

@@ tb/fuzzy_implication_matrix_cell_tb.sv @@
// ----------------------------------------------------------------------------
// fuzzy_implication_matrix_cell_tb
// self-checking bench for one cell of the fuzzy implication matrix composition
// ----------------------------------------------------------------------------
// element requests go in on the s_* stream and cell results come back on m_*.
// a fixed-point model of the cell folds every accepted element into its own
// running products and queues the expected c on each last element. a short
// table of hand-picked elements runs first, then random vectors and long
// growth vectors under three sender/receiver idling mixes, with one long
// receiver stall and pauses that let the block drain.
// ----------------------------------------------------------------------------
module fuzzy_implication_matrix_cell_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_BITS   = fimc_pkg::FRAC_BITS;
    localparam int     IN_W        = fimc_pkg::IN_W;
    localparam int     C_W         = fimc_pkg::C_W;
    localparam int     TDATA_IN_W  = fimc_pkg::TDATA_IN_W;
    localparam int     TDATA_OUT_W = fimc_pkg::TDATA_OUT_W;
    localparam longint F_MAX       = fimc_pkg::F_MAX;
    localparam longint F_MIN       = fimc_pkg::F_MIN;
    localparam longint C_MAX       = fimc_pkg::C_MAX;
    localparam longint C_MIN       = fimc_pkg::C_MIN;

    localparam longint UNIT = longint'(fimc_pkg::Q_ONE);
    localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] e;
        logic [IN_W-1:0] g;
        logic            last;
        logic            typed;
        logic [C_W-1:0]  c;
    } element_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;

    logic [C_W-1:0] cell_results_q [$];
    longint         f_running;
    longint         notd_running;
    int             error_count;
    int             sent_count;
    int             sender_idle_pct;
    int             reader_idle_pct;
    int             stall_cycles;
    bit             arm_stall;

    element_row_t directed_rows [17] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 21'd0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1, 21'd32768},
        '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1, 1'b1, 21'd32768},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 21'd32768},
        '{16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0, 21'd0},
        '{16'h8000, 16'h0000, 16'h8000, 16'h8000, 1'b1, 1'b0, 21'd0},
        '{16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b0, 1'b0, 21'd0},
        '{16'h7FFF, 16'h8001, 16'h6000, 16'h2000, 1'b0, 1'b0, 21'd0},
        '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 21'd0},
        '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 21'd0},
        '{16'h8000, 16'h0001, 16'h0001, 16'h7FFF, 1'b0, 1'b0, 21'd0},
        '{16'h0001, 16'h7FFF, 16'h7FFF, 16'h0001, 1'b1, 1'b0, 21'd0},
        '{16'hFFFF, 16'h0000, 16'h8000, 16'h4000, 1'b1, 1'b0, 21'd0},
        '{16'h0000, 16'hFFFF, 16'h4000, 16'hFFFF, 1'b0, 1'b0, 21'd0},
        '{16'h6000, 16'h6000, 16'h6000, 16'h6000, 1'b0, 1'b0, 21'd0},
        '{16'h2000, 16'h1000, 16'h7000, 16'h5555, 1'b1, 1'b0, 21'd0},
        '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 21'd0}
    };

    fuzzy_implication_matrix_cell uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic longint scaled_mul(input longint x, input longint y);
        longint mx;
        longint my;
        longint r;
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        r  = (mx * my + HALF) >>> FRAC_BITS;
        return ((x < 0) != (y < 0)) ? -r : r;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint to_unit(input logic [IN_W-1:0] v);
        return (longint'(v) > UNIT) ? UNIT : longint'(v);
    endfunction

    // folds one element into the running products, returns 1 when c is due
    function automatic bit fold_element(input logic [IN_W-1:0] a_in, b_in, e_in, g_in,
                                        input logic last_in, output logic [C_W-1:0] c_out);
        longint a, b, e, g;
        longint imp1, imp2, t1, u, t2, fv, dv;
        longint dd, hh, x, y, z, c;
        a    = to_unit(a_in);
        b    = to_unit(b_in);
        e    = to_unit(e_in);
        g    = to_unit(g_in);
        imp1 = (UNIT - a > b) ? UNIT - a : b;
        imp2 = (UNIT - b > a) ? UNIT - b : a;
        t1   = scaled_mul(imp1, 2 * e - UNIT);
        u    = UNIT + scaled_mul(4 * imp1 - 2 * UNIT, e);
        t2   = scaled_mul(scaled_mul(imp2, u), UNIT - e);
        fv   = t1 + t2;
        dv   = (a < b) ? a : b;
        f_running    = clip(scaled_mul(f_running, fv), F_MIN, F_MAX);
        notd_running = scaled_mul(notd_running, UNIT - dv);
        c_out = '0;
        if (!last_in)
            return 1'b0;
        dd = UNIT - notd_running;
        hh = f_running + dd - UNIT;
        if (hh < 0)
            hh = 0;
        x = scaled_mul(scaled_mul(f_running, 3 * g - 2 * UNIT), g);
        y = dd + scaled_mul(4 * hh - 3 * dd, g);
        z = scaled_mul(y, UNIT - g);
        c = clip(x + z, C_MIN, C_MAX);
        c_out = c[C_W-1:0];
        f_running    = UNIT;
        notd_running = UNIT;
        return 1'b1;
    endfunction

    function automatic logic [IN_W-1:0] rand_level();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(65535));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // entered and left at a falling edge, valid stays high for a following request
    task automatic send_item(input logic [IN_W-1:0] a, b, e, g, input logic last_in,
                             input logic typed, input logic [C_W-1:0] c_typed);
        logic [C_W-1:0] c_pred;
        bit             emits;
        if ($urandom_range(7) == 0 && sender_idle_pct != 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {g, e, b, a};
        s_tlast  <= last_in;
        do
            @(posedge clk);
        while (!s_tready);
        emits = fold_element(a, b, e, g, last_in, c_pred);
        if (emits)
            cell_results_q.insert(cell_results_q.size(), typed ? c_typed : c_pred);
        if (arm_stall)
        begin
            stall_cycles = 600;
            arm_stall    = 1'b0;
        end
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_item(rand_level(), rand_level(), rand_level(), rand_level(),
                      i == len - 1, 1'b0, '0);
    endtask

    // f near 1.125 per element drives the running product into saturation
    task automatic send_growth(input int len, input bit negative_start,
                               input logic [IN_W-1:0] g);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0 && negative_start)
                send_item(16'h0000, 16'h8000, 16'h0000, g, 1'b0, 1'b0, '0);
            else
                send_item(16'h8000, 16'h8000, 16'(24576 + $urandom_range(512) - 256), g,
                          i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (cell_results_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_cycles > 0)
            begin
                stall_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= reader_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [C_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cell_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = cell_results_q.pop_front();
                if (m_tdata !== {{(TDATA_OUT_W-C_W){1'b0}}, want})
                begin
                    $display("%0t: c_value mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int mark;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        error_count     = 0;
        sent_count      = 0;
        stall_cycles    = 0;
        arm_stall       = 1'b0;
        sender_idle_pct = 36;
        reader_idle_pct = 63;
        f_running       = UNIT;
        notd_running    = UNIT;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].a, directed_rows[i].b, directed_rows[i].e,
                      directed_rows[i].g, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].c);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            sender_idle_pct = (p == 0) ? 36 : (p == 1) ? 63 : 0;
            reader_idle_pct = (p == 0) ? 63 : (p == 1) ? 36 : 0;
            mark = sent_count;
            if (p == 0)
                arm_stall = 1'b1;
            while (sent_count - mark < 300)
                send_vector(($urandom_range(7) == 0) ? $urandom_range(5, 16)
                                                     : $urandom_range(1, 4));
            send_growth(190, p == 1, (p == 0) ? 16'h8000 : (p == 1) ? 16'h4000
                                                                  : rand_level());
            drain();
        end

        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ fuzzy_implication_matrix_cell.f @@
src/fimc_pkg.sv
src/fuzzy_implication_matrix_cell.sv
tb/fuzzy_implication_matrix_cell_tb.sv
